@@ rtl/mtst_pkg.sv @@
// ----------------------------------------------------------------------------
// mtst_pkg
// Shared constants for the multi-touch to single-touch translator: event
// types, axis and key codes, and default parameter values.
// ----------------------------------------------------------------------------
package mtst_pkg;

    // default configuration
    localparam int          DEF_SLOT_COUNT = 16;
    localparam logic        DEF_MT_SOURCE  = 1'b1;

    // field widths
    localparam int          TYPE_W  = 16;
    localparam int          CODE_W  = 16;
    localparam int          VALUE_W = 32;
    localparam int          DATA_W  = TYPE_W + CODE_W + VALUE_W;

    // event types
    localparam logic [15:0] EVT_SYN = 16'h0000;
    localparam logic [15:0] EVT_KEY = 16'h0001;
    localparam logic [15:0] EVT_ABS = 16'h0003;

    // axis codes
    localparam logic [15:0] AXIS_X        = 16'h0000;
    localparam logic [15:0] AXIS_Y        = 16'h0001;
    localparam logic [15:0] AXIS_MT_SLOT  = 16'h002f;
    localparam logic [15:0] AXIS_MT_X     = 16'h0035;
    localparam logic [15:0] AXIS_MT_Y     = 16'h0036;
    localparam logic [15:0] AXIS_MT_TRACK = 16'h0039;

    // key and sync codes
    localparam logic [15:0] KEY_TOUCH   = 16'h014a;
    localparam logic [15:0] SYNC_REPORT = 16'h0000;

endpackage

@@ rtl/mtst_ram.sv @@
// ----------------------------------------------------------------------------
// mtst_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port; read data holds while no read is requested.
// ----------------------------------------------------------------------------
module mtst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/multitouch_to_single_touch.sv @@
// ----------------------------------------------------------------------------
// multitouch_to_single_touch
// Translates slot-based multi-touch input events into single-touch events.
// ----------------------------------------------------------------------------
// Each input beat is one event (type, code, value). Slot, MT X, MT Y and
// tracking id events only update internal state and produce no output beat;
// X/Y axis and key events pass through as one beat (a multi-touch source's
// own touch key is dropped). A sync report produces one to four beats:
// touch-down or touch-up key, X, Y of the lowest active slot, then the sync
// itself, with tlast on the final beat. An event that yields zero or one beat
// is taken every cycle while the output is not stalled; a sync report holds
// the input until its last beat loads the single output register. X and Y live
// in two small RAMs read once per sync report; per-slot written bits make a
// never-written position read as zero, so no clearing pass runs after reset.
// The mt_source register (reset 1) is written through the cfg channel.
// ----------------------------------------------------------------------------
module multitouch_to_single_touch #(
    parameter int SLOT_COUNT = mtst_pkg::DEF_SLOT_COUNT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input events
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [15:0] event_type, [31:16] event_code, [63:32] event_value
    input  logic [mtst_pkg::DATA_W-1:0] s_axis_tdata,
    // output events
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [15:0] out_type, [31:16] out_code, [63:32] out_value
    output logic [mtst_pkg::DATA_W-1:0] m_axis_tdata,
    output logic                        m_axis_tlast,
    // configuration: mt_source
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [0:0]                  i_cfg_data
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // pending beat bits, emitted from lowest to highest
    localparam int B_KEY  = 0;
    localparam int B_X    = 1;
    localparam int B_Y    = 2;
    localparam int B_SYNC = 3;
    localparam int B_PASS = 4;
    localparam int PEND_W = 5;

    // input fields
    logic [15:0] in_type;
    logic [15:0] in_code;
    logic [31:0] in_value;

    assign in_type  = s_axis_tdata[15:0];
    assign in_code  = s_axis_tdata[31:16];
    assign in_value = s_axis_tdata[63:32];

    // control state
    logic                  r_mt_source;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_slot_in_range;
    logic [SLOT_COUNT-1:0] r_active;
    logic [SLOT_COUNT-1:0] r_x_ok;
    logic [SLOT_COUNT-1:0] r_y_ok;
    logic                  r_touch_down;
    logic [PEND_W-1:0]     r_pend;
    logic                  r_o_valid;

    // payload
    logic [15:0]           r_pass_type;
    logic [15:0]           r_pass_code;
    logic [31:0]           r_pass_value;
    logic                  r_touch_val;
    logic                  r_rd_x_ok;
    logic                  r_rd_y_ok;
    logic [15:0]           r_o_type;
    logic [15:0]           r_o_code;
    logic [31:0]           r_o_value;
    logic                  r_o_last;

    logic                  s_acc;
    logic                  is_abs;
    logic                  is_key;
    logic                  is_sync;
    logic                  slot_val_ok;
    logic                  x_we;
    logic                  y_we;
    logic                  trk_we;
    logic                  pass_item;
    logic                  any_active;
    logic [SLOT_W-1:0]     first_slot;
    logic [PEND_W-1:0]     n_pend;
    logic [31:0]           x_rdata;
    logic [31:0]           y_rdata;

    logic                  beat_valid;
    logic                  beat_last;
    logic                  out_load;
    logic                  beat_take;
    logic [PEND_W-1:0]     beat_sel;
    logic [15:0]           beat_type;
    logic [15:0]           beat_code;
    logic [31:0]           beat_value;

    // decode of the input beat
    assign s_acc       = s_axis_tvalid && s_axis_tready;
    assign is_abs      = (in_type == mtst_pkg::EVT_ABS);
    assign is_key      = (in_type == mtst_pkg::EVT_KEY);
    assign is_sync     = (in_type == mtst_pkg::EVT_SYN) && (in_code == mtst_pkg::SYNC_REPORT);
    assign slot_val_ok = !in_value[31] && (in_value < 32'(SLOT_COUNT));
    assign x_we   = s_acc && is_abs && (in_code == mtst_pkg::AXIS_MT_X) && r_slot_in_range;
    assign y_we   = s_acc && is_abs && (in_code == mtst_pkg::AXIS_MT_Y) && r_slot_in_range;
    assign trk_we = s_acc && is_abs && (in_code == mtst_pkg::AXIS_MT_TRACK) && r_slot_in_range;
    assign pass_item = (is_abs && ((in_code == mtst_pkg::AXIS_X) || (in_code == mtst_pkg::AXIS_Y)))
                    || (is_key && !((in_code == mtst_pkg::KEY_TOUCH) && r_mt_source));

    // lowest active slot
    always_comb begin
        any_active = 1'b0;
        first_slot = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_active[i]) begin
                any_active = 1'b1;
                first_slot = SLOT_W'(i);
            end
        end
    end

    // beats planned for the accepted item
    always_comb begin
        n_pend = '0;
        if (pass_item) begin
            n_pend[B_PASS] = 1'b1;
        end else if (is_sync) begin
            n_pend[B_KEY]  = any_active ? !r_touch_down : r_touch_down;
            n_pend[B_X]    = any_active;
            n_pend[B_Y]    = any_active;
            n_pend[B_SYNC] = 1'b1;
        end
    end

    // position memories
    mtst_ram #(
        .WIDTH (32),
        .DEPTH (SLOT_COUNT)
    ) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (x_we),
        .i_waddr (r_slot),
        .i_wdata (in_value),
        .i_re    (s_acc && is_sync),
        .i_raddr (first_slot),
        .o_rdata (x_rdata)
    );

    mtst_ram #(
        .WIDTH (32),
        .DEPTH (SLOT_COUNT)
    ) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (y_we),
        .i_waddr (r_slot),
        .i_wdata (in_value),
        .i_re    (s_acc && is_sync),
        .i_raddr (first_slot),
        .o_rdata (y_rdata)
    );

    // beat sequencing from the pending bits
    assign beat_valid = |r_pend;
    assign beat_sel   = r_pend & (~r_pend + PEND_W'(1));
    assign beat_last  = beat_valid && ((r_pend & (r_pend - PEND_W'(1))) == '0);
    assign out_load   = !r_o_valid || m_axis_tready;
    assign beat_take  = beat_valid && out_load;

    assign s_axis_tready = !beat_valid || (beat_last && out_load);
    assign o_cfg_ready   = 1'b1;

    // fields of the next output beat
    always_comb begin
        beat_type  = mtst_pkg::EVT_SYN;
        beat_code  = mtst_pkg::SYNC_REPORT;
        beat_value = '0;
        priority if (r_pend[B_KEY]) begin
            beat_type  = mtst_pkg::EVT_KEY;
            beat_code  = mtst_pkg::KEY_TOUCH;
            beat_value = {31'd0, r_touch_val};
        end else if (r_pend[B_X]) begin
            beat_type  = mtst_pkg::EVT_ABS;
            beat_code  = mtst_pkg::AXIS_X;
            beat_value = r_rd_x_ok ? x_rdata : '0;
        end else if (r_pend[B_Y]) begin
            beat_type  = mtst_pkg::EVT_ABS;
            beat_code  = mtst_pkg::AXIS_Y;
            beat_value = r_rd_y_ok ? y_rdata : '0;
        end else if (r_pend[B_SYNC]) begin
            beat_type  = mtst_pkg::EVT_SYN;
            beat_code  = mtst_pkg::SYNC_REPORT;
            beat_value = '0;
        end else begin
            beat_type  = r_pass_type;
            beat_code  = r_pass_code;
            beat_value = r_pass_value;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mt_source     <= mtst_pkg::DEF_MT_SOURCE;
            r_slot          <= '0;
            r_slot_in_range <= 1'b1;
            r_active        <= '0;
            r_x_ok          <= '0;
            r_y_ok          <= '0;
            r_touch_down    <= 1'b0;
            r_pend          <= '0;
            r_o_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mt_source <= i_cfg_data[0];
            end
            // slot selection
            if (s_acc && is_abs && (in_code == mtst_pkg::AXIS_MT_SLOT)) begin
                if (slot_val_ok) begin
                    r_slot          <= in_value[SLOT_W-1:0];
                    r_slot_in_range <= 1'b1;
                end else begin
                    r_slot_in_range <= 1'b0;
                end
            end
            // per-slot flags
            if (x_we) begin
                r_x_ok[r_slot] <= 1'b1;
            end
            if (y_we) begin
                r_y_ok[r_slot] <= 1'b1;
            end
            if (trk_we) begin
                r_active[r_slot] <= !in_value[31];
            end
            if (s_acc && is_sync) begin
                r_touch_down <= any_active;
            end
            // pending beats
            if (s_acc) begin
                r_pend <= n_pend;
            end else if (beat_take) begin
                r_pend <= r_pend & ~beat_sel;
            end
            // output register
            if (out_load) begin
                r_o_valid <= beat_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_pass_type  <= in_type;
            r_pass_code  <= in_code;
            r_pass_value <= in_value;
        end
        if (s_acc && is_sync) begin
            r_touch_val <= any_active;
            r_rd_x_ok   <= r_x_ok[first_slot];
            r_rd_y_ok   <= r_y_ok[first_slot];
        end
        if (beat_take) begin
            r_o_type  <= beat_type;
            r_o_code  <= beat_code;
            r_o_value <= beat_value;
            r_o_last  <= beat_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_value, r_o_code, r_o_type};
    assign m_axis_tlast  = r_o_last;

    // a pass-through item never shares its run with other beats
    a_pass_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend[B_PASS] |-> $onehot(r_pend))
        else $error("pass-through beat mixed with sync beats");

    // x is never pending without y behind it
    a_x_then_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend[B_X] |-> r_pend[B_Y])
        else $error("x beat pending without y beat");

    // an accepted sync report always queues its sync beat
    a_sync_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && is_sync) |=> r_pend[B_SYNC])
        else $error("sync report did not queue a sync beat");

    // input is only taken when at most the final beat remains
    a_ready_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> ((r_pend == '0) || $onehot(r_pend)))
        else $error("input taken while several beats remain");

    // an active slot at a sync report leaves the touch down
    a_touch_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && is_sync && any_active) |=> r_touch_down)
        else $error("touch not marked down after active sync");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-touch to single-touch translator. Event
// beats go in through the input stream: directed corner cases first, then
// random touch frames with random slots, positions and tracking ids, mixed
// with stray events. A behavioral model inside the bench predicts every
// output beat. The checker compares each output beat field by field with the
// oldest prediction. Both stream sides idle at random, with one stretch
// without idling and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SLOTS      = mtst_pkg::DEF_SLOT_COUNT;
    localparam int TYPE_W     = mtst_pkg::TYPE_W;
    localparam int CODE_W     = mtst_pkg::CODE_W;
    localparam int VALUE_W    = mtst_pkg::VALUE_W;
    localparam int DATA_W     = mtst_pkg::DATA_W;
    localparam int SETTLE_CYC = 16;
    localparam int HOLD_CYC   = 120;

    // one predicted or observed output beat
    typedef struct packed {
        logic [TYPE_W-1:0]  ev_type;
        logic [CODE_W-1:0]  ev_code;
        logic [VALUE_W-1:0] ev_value;
        logic               last;
    } t_touch_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [15:0] event_type, [31:16] event_code, [63:32] event_value
    logic [DATA_W-1:0]    s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [15:0] out_type, [31:16] out_code, [63:32] out_value
    logic [DATA_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [0:0]           i_cfg_data = '0;

    // translator model state
    logic                 mdl_mt_source = mtst_pkg::DEF_MT_SOURCE;
    int                   mdl_slot = 0;
    logic                 mdl_slot_ok = 1'b1;
    logic                 mdl_active [SLOTS] = '{default: 1'b0};
    logic [VALUE_W-1:0]   mdl_x [SLOTS] = '{default: '0};
    logic [VALUE_W-1:0]   mdl_y [SLOTS] = '{default: '0};
    logic                 mdl_touch = 1'b0;

    t_touch_beat          pending_beats [$];
    t_touch_beat          head_beat;
    t_touch_beat          seen_beat;
    int                   mismatch_count = 0;

    // stall control
    bit                   tx_idle_en = 1'b1;
    bit                   rx_idle_en = 1'b1;
    int                   hold_req = 0;
    int                   hold_seen = 0;
    int                   hold_left = 0;

    multitouch_to_single_touch #(
        .SLOT_COUNT(SLOTS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    function automatic void push_beat(input logic [TYPE_W-1:0] t,
                                      input logic [CODE_W-1:0] c,
                                      input logic [VALUE_W-1:0] v);
        t_touch_beat b;
        b.ev_type  = t;
        b.ev_code  = c;
        b.ev_value = v;
        b.last     = 1'b0;
        pending_beats.push_back(b);
    endfunction

    // predict the output beats caused by one accepted input event
    function automatic void translate_event(input logic [TYPE_W-1:0] t,
                                            input logic [CODE_W-1:0] c,
                                            input logic [VALUE_W-1:0] v);
        int  n_out;
        int  first_slot;
        logic neg;
        n_out = 0;
        first_slot = -1;
        neg = v[VALUE_W-1];
        if (t == mtst_pkg::EVT_ABS) begin
            case (c)
                mtst_pkg::AXIS_MT_SLOT: begin
                    if (!neg && v < SLOTS) begin
                        mdl_slot = int'(v);
                        mdl_slot_ok = 1'b1;
                    end else begin
                        mdl_slot_ok = 1'b0;
                    end
                end
                mtst_pkg::AXIS_MT_X: if (mdl_slot_ok) mdl_x[mdl_slot] = v;
                mtst_pkg::AXIS_MT_Y: if (mdl_slot_ok) mdl_y[mdl_slot] = v;
                mtst_pkg::AXIS_MT_TRACK: if (mdl_slot_ok) mdl_active[mdl_slot] = !neg;
                mtst_pkg::AXIS_X, mtst_pkg::AXIS_Y: begin
                    push_beat(mtst_pkg::EVT_ABS, c, v);
                    n_out++;
                end
                default: ;
            endcase
        end else if (t == mtst_pkg::EVT_KEY) begin
            if (!(c == mtst_pkg::KEY_TOUCH && mdl_mt_source)) begin
                push_beat(mtst_pkg::EVT_KEY, c, v);
                n_out++;
            end
        end else if (t == mtst_pkg::EVT_SYN && c == mtst_pkg::SYNC_REPORT) begin
            for (int i = SLOTS - 1; i >= 0; i--)
                if (mdl_active[i]) first_slot = i;
            if (first_slot >= 0) begin
                if (!mdl_touch) begin
                    push_beat(mtst_pkg::EVT_KEY, mtst_pkg::KEY_TOUCH, 32'd1);
                    n_out++;
                end
                push_beat(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_X, mdl_x[first_slot]);
                push_beat(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_Y, mdl_y[first_slot]);
                n_out += 2;
                mdl_touch = 1'b1;
            end else if (mdl_touch) begin
                push_beat(mtst_pkg::EVT_KEY, mtst_pkg::KEY_TOUCH, 32'd0);
                n_out++;
                mdl_touch = 1'b0;
            end
            push_beat(mtst_pkg::EVT_SYN, mtst_pkg::SYNC_REPORT, 32'd0);
            n_out++;
        end
        if (n_out > 0)
            pending_beats[pending_beats.size() - 1].last = 1'b1;
    endfunction

    // send one event beat, with an optional random gap in front
    task automatic send_event(input logic [TYPE_W-1:0] t,
                              input logic [CODE_W-1:0] c,
                              input logic [VALUE_W-1:0] v);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 99) < 35)
            gap = $urandom_range(1, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, c, t};
        do @(posedge i_clk); while (!s_axis_tready);
        translate_event(t, c, v);
    endtask

    // wait until every predicted beat has come out and the block is quiet
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_mt_source(input logic val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        mdl_mt_source = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // output side: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_left = HOLD_CYC;
            hold_seen = hold_req;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_en) begin
            m_axis_tready <= ($urandom_range(0, 99) >= 35);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each output beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_beat = {m_axis_tdata[TYPE_W-1:0],
                         m_axis_tdata[TYPE_W+CODE_W-1:TYPE_W],
                         m_axis_tdata[DATA_W-1:TYPE_W+CODE_W],
                         m_axis_tlast};
            if (pending_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat type %0h code %0h value %0d",
                    seen_beat.ev_type, seen_beat.ev_code, $signed(seen_beat.ev_value)));
            end else begin
                head_beat = pending_beats.pop_front();
                if (seen_beat !== head_beat)
                    report_mismatch($sformatf(
                        "got %0h/%0h/%0d last %0b, want %0h/%0h/%0d last %0b",
                        seen_beat.ev_type, seen_beat.ev_code,
                        $signed(seen_beat.ev_value), seen_beat.last,
                        head_beat.ev_type, head_beat.ev_code,
                        $signed(head_beat.ev_value), head_beat.last));
            end
        end
    end

    // one touch frame with random slots, ids and positions, ending in a sync
    task automatic send_random_frame(output int n_sent);
        int n_slots;
        int r;
        logic [VALUE_W-1:0] v;
        n_sent = 0;
        n_slots = $urandom_range(1, 3);
        for (int k = 0; k < n_slots; k++) begin
            r = $urandom_range(0, 99);
            if (r < 86)
                v = $urandom_range(0, SLOTS - 1);
            else if (r < 93)
                v = SLOTS + $urandom_range(0, 200);
            else
                v = $urandom | 32'h8000_0000;
            send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_SLOT, v);
            n_sent++;
            if ($urandom_range(0, 99) < 60) begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    v = $urandom_range(0, 65535);
                else if (r < 90)
                    v = 32'hffff_ffff;
                else
                    v = $urandom;
                send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_TRACK, v);
                n_sent++;
            end
            if ($urandom_range(0, 99) < 80) begin
                send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_X, $urandom);
                send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_Y, $urandom);
                n_sent += 2;
            end
        end
        if ($urandom_range(0, 99) < 20) begin
            send_event(mtst_pkg::EVT_KEY,
                       ($urandom_range(0, 1) != 0) ? mtst_pkg::KEY_TOUCH : CODE_W'($urandom),
                       $urandom_range(0, 2));
            n_sent++;
        end
        if ($urandom_range(0, 99) < 15) begin
            send_event(mtst_pkg::EVT_ABS,
                       ($urandom_range(0, 1) != 0) ? mtst_pkg::AXIS_X : mtst_pkg::AXIS_Y,
                       $urandom);
            n_sent++;
        end
        send_event(mtst_pkg::EVT_SYN, mtst_pkg::SYNC_REPORT, 32'd0);
        n_sent++;
    endtask

    // stray event: any type, code and value, mostly ignored by the block
    task automatic send_stray_event();
        case ($urandom_range(0, 3))
            0: send_event(mtst_pkg::EVT_SYN, CODE_W'($urandom_range(1, 65535)), $urandom);
            1: send_event(mtst_pkg::EVT_ABS, CODE_W'($urandom), $urandom);
            default: send_event(TYPE_W'($urandom), CODE_W'($urandom), $urandom);
        endcase
    endtask

    // corner cases of every field and every event kind
    task automatic test_directed();
        // no touch: sync only
        send_event(mtst_pkg::EVT_SYN, mtst_pkg::SYNC_REPORT, 32'd0);
        // touch key dropped for mt source, other keys and X/Y pass through
        send_event(mtst_pkg::EVT_KEY, mtst_pkg::KEY_TOUCH, 32'd1);
        send_event(mtst_pkg::EVT_KEY, 16'hffff, 32'h7fff_ffff);
        send_event(mtst_pkg::EVT_KEY, 16'h0000, 32'h8000_0000);
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_X, 32'h8000_0000);
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_Y, 32'hffff_ffff);
        // slot out of range: negative, one past the end, largest positive
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_SLOT, 32'hffff_ffff);
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_TRACK, 32'd0);    // ignored
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_SLOT, SLOTS);
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_X, 32'd77);       // ignored
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_SLOT, 32'h7fff_ffff);
        send_event(mtst_pkg::EVT_SYN, mtst_pkg::SYNC_REPORT, 32'd0);
        // last slot becomes active: touch-down, x, y, sync
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_SLOT, SLOTS - 1);
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_TRACK, 32'd0);
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_X, 32'h7fff_ffff);
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_Y, 32'h8000_0000);
        send_event(mtst_pkg::EVT_SYN, mtst_pkg::SYNC_REPORT, 32'd0);
        // slot 0 joins and wins as lowest, never-written position reads zero
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_SLOT, 32'd0);
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_TRACK, 32'h7fff_ffff);
        send_event(mtst_pkg::EVT_SYN, mtst_pkg::SYNC_REPORT, 32'd0);
        // both released: touch-up then sync, then sync alone
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_TRACK, 32'h8000_0000);
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_SLOT, SLOTS - 1);
        send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_TRACK, 32'hffff_ffff);
        send_event(mtst_pkg::EVT_SYN, mtst_pkg::SYNC_REPORT, 32'd0);
        send_event(mtst_pkg::EVT_SYN, mtst_pkg::SYNC_REPORT, 32'd0);
        // unknown type, unknown axis, non-report sync
        send_event(16'hffff, 16'hffff, 32'hffff_ffff);
        send_event(mtst_pkg::EVT_ABS, 16'hffff, 32'd5);
        send_event(mtst_pkg::EVT_SYN, 16'hffff, 32'd0);
        wait_idle();
    endtask

    // touch key passes through only for a single-touch source
    task automatic test_mt_source_config();
        write_mt_source(1'b0);
        send_event(mtst_pkg::EVT_KEY, mtst_pkg::KEY_TOUCH, 32'd1);
        send_event(mtst_pkg::EVT_KEY, mtst_pkg::KEY_TOUCH, 32'd0);
        write_mt_source(1'b1);
        send_event(mtst_pkg::EVT_KEY, mtst_pkg::KEY_TOUCH, 32'd1);
        send_event(mtst_pkg::EVT_KEY, 16'h0110, 32'd1);
        wait_idle();
    endtask

    task automatic test_random_traffic(input logic mt_src, input int n_items);
        int done;
        int n;
        done = 0;
        write_mt_source(mt_src);
        while (done < n_items) begin
            if ($urandom_range(0, 99) < 12) begin
                send_stray_event();
                done++;
            end else begin
                send_random_frame(n);
                done += n;
            end
        end
        wait_idle();
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_no_idle_burst();
        int done;
        int n;
        done = 0;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        while (done < 10) begin
            send_random_frame(n);
            done += n;
        end
        wait_idle();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // output held off while full touch frames keep coming in
    task automatic test_output_hold();
        hold_req++;
        for (int k = 0; k < 4; k++) begin
            send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_SLOT, k);
            send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_TRACK, k);
            send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_X, $urandom);
            send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_Y, $urandom);
            send_event(mtst_pkg::EVT_SYN, mtst_pkg::SYNC_REPORT, 32'd0);
        end
        for (int k = 0; k < 4; k++) begin
            send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_SLOT, k);
            send_event(mtst_pkg::EVT_ABS, mtst_pkg::AXIS_MT_TRACK, 32'hffff_ffff);
        end
        send_event(mtst_pkg::EVT_SYN, mtst_pkg::SYNC_REPORT, 32'd0);
        wait_idle();
    endtask

    initial begin
        int guard;
        guard = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_mt_source_config();
        test_random_traffic(1'b0, 15);
        test_random_traffic(1'b1, 15);
        test_no_idle_burst();
        test_output_hold();

        // drain with a bound, then let the block settle
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (pending_beats.size() != 0)
            report_mismatch($sformatf("%0d predicted beats never came out",
                                      pending_beats.size()));
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ multitouch_to_single_touch.f @@
rtl/mtst_pkg.sv
rtl/mtst_ram.sv
rtl/multitouch_to_single_touch.sv
tb/sv/testbench.sv
